/* hw/rtl/u16u8_pkg.sv */
package u16u8_pkg;

  localparam int unsigned MAX_BYTES       = 6;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam logic [5:0] LEAD_PREFIX  = 6'b110110;
  localparam logic [5:0] TRAIL_PREFIX = 6'b110111;

  // One input item's worth of output bytes, byte 0 first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [MAX_BYTES-1:0]      repl;
    logic [2:0]                count;
  } u16u8_job_t;

endpackage

/* hw/rtl/u16u8_front.sv */
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [15:0] code_unit,
  input  logic       end_of_string,
  output u16u8_job_t job,
  output logic       job_valid
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [9:0] pend_bits_r, pend_bits_nxt;

  logic        is_lead, is_trail, done, lead_held;
  logic [20:0] cp;
  logic [3:0][7:0] head_bytes;
  logic [2:0][7:0] tail_bytes;
  logic [2:0]  head_len, tail_len;
  logic        head_repl, tail_repl;

  always_comb begin
    is_lead   = (code_unit[15:10] == LEAD_PREFIX);
    is_trail  = (code_unit[15:10] == TRAIL_PREFIX);
    done      = pend_valid_r && is_trail;
    lead_held = !done && is_lead;
    cp        = SUPP_BASE + {1'b0, pend_bits_r, code_unit[9:0]};

    head_bytes = '0;
    head_len   = 3'd0;
    head_repl  = 1'b0;
    if (done) begin
      head_bytes[0] = LEAD4_MARK | {5'b0, cp[20:18]};
      head_bytes[1] = CONT_MARK | {2'b0, cp[17:12]};
      head_bytes[2] = CONT_MARK | {2'b0, cp[11:6]};
      head_bytes[3] = CONT_MARK | {2'b0, cp[5:0]};
      head_len      = 3'd4;
    end else if (pend_valid_r) begin
      head_bytes[0] = REPL_BYTE0;
      head_bytes[1] = REPL_BYTE1;
      head_bytes[2] = REPL_BYTE2;
      head_len      = 3'd3;
      head_repl     = 1'b1;
    end

    tail_bytes = '0;
    tail_len   = 3'd0;
    tail_repl  = 1'b0;
    if (done) begin
      tail_len = 3'd0;
    end else if (code_unit <= ONE_BYTE_MAX) begin
      tail_bytes[0] = code_unit[7:0];
      tail_len      = 3'd1;
    end else if (code_unit <= TWO_BYTE_MAX) begin
      tail_bytes[0] = LEAD2_MARK | {3'b0, code_unit[10:6]};
      tail_bytes[1] = CONT_MARK | {2'b0, code_unit[5:0]};
      tail_len      = 3'd2;
    end else if (is_trail || (is_lead && end_of_string)) begin
      // A lone trail, or a lead that the string ends on, becomes U+FFFD.
      tail_bytes[0] = REPL_BYTE0;
      tail_bytes[1] = REPL_BYTE1;
      tail_bytes[2] = REPL_BYTE2;
      tail_len      = 3'd3;
      tail_repl     = 1'b1;
    end else if (!is_lead) begin
      tail_bytes[0] = LEAD3_MARK | {4'b0, code_unit[15:12]};
      tail_bytes[1] = CONT_MARK | {2'b0, code_unit[11:6]};
      tail_bytes[2] = CONT_MARK | {2'b0, code_unit[5:0]};
      tail_len      = 3'd3;
    end

    job       = '0;
    job.count = head_len + tail_len;
    if (head_len == 3'd0) begin
      job.bytes[2:0] = tail_bytes;
      job.repl[2:0]  = {3{tail_repl}};
    end else begin
      job.bytes[3:0] = head_bytes;
      job.repl[2:0]  = {3{head_repl}};
      if (head_len == 3'd3) begin
        job.bytes[5:3] = tail_bytes;
        job.repl[5:3]  = {3{tail_repl}};
      end
    end
    job_valid = (job.count != 3'd0);

    pend_valid_nxt = pend_valid_r;
    pend_bits_nxt  = pend_bits_r;
    if (accept) begin
      pend_valid_nxt = lead_held && !end_of_string;
      if (lead_held) begin
        pend_bits_nxt = code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_bits_r  <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_bits_r  <= pend_bits_nxt;
    end
  end

endmodule

/* hw/rtl/u16u8_fifo.sv */
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u16u8_job_t push_job,
  input  logic       pop,
  output u16u8_job_t head_job,
  output logic       not_empty,
  output logic       full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u16u8_job_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    not_empty  = (count_r != '0);
    full       = (count_r == CW'(DEPTH));
    head_job   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("queue written while full");

endmodule

/* hw/rtl/u16u8_back.sv */
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  u16u8_job_t head_job,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast,   // run_last
  output logic       out_tuser    // is_replacement
);

  u16u8_job_t job_r, job_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_repl_r, out_repl_nxt;
  logic       advance;

  // The output register reloads when empty or being taken, so a new byte
  // goes out every cycle out_tready is high and a job waits, across jobs too.
  always_comb begin
    advance       = !out_valid_r || out_tready;
    pop           = 1'b0;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_repl_nxt  = out_repl_r;

    if (advance) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = job_r.bytes[idx_r];
        out_repl_nxt  = job_r.repl[idx_r];
        out_last_nxt  = (idx_r == job_r.count - 3'd1);
        idx_nxt       = idx_r + 3'd1;
        if (idx_r == job_r.count - 3'd1) begin
          busy_nxt = 1'b0;
        end
      end else if (head_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = head_job.bytes[0];
        out_repl_nxt  = head_job.repl[0];
        out_last_nxt  = (head_job.count == 3'd1);
        job_nxt       = head_job;
        idx_nxt       = 3'd1;
        busy_nxt      = (head_job.count != 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_repl_r <= out_repl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_repl_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < job_r.count) && (job_r.count <= 3'(MAX_BYTES)))
    else $error("byte index ran past the job");

  a_single_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_job.count == 3'd1) |=> (out_tvalid && out_tlast && !busy_r))
    else $error("single-byte job not marked last");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("queue popped while a job is in flight");

endmodule

/* hw/rtl/utf16_to_utf8_encoder.sv */
// UTF-16 to UTF-8 encoder. Each input beat carries one UTF-16 code unit
// (in_tdata[15:0]) and an end-of-string flag (in_tlast); each output beat
// carries one UTF-8 byte, with out_tlast on the last byte an input beat
// produces and out_tuser on bytes of an emitted U+FFFD. A lead surrogate
// produces nothing until the next unit arrives; unpaired surrogates become
// EF BF BD, including a lead still held when the string ends. The front end
// classifies a unit and builds all of its bytes (up to six) combinationally
// and takes a beat every cycle while the job queue has room; the back end
// sends one byte per cycle while out_tready is high, so the sustained input
// rate falls with the bytes each beat produces (1 to 6, typically 1 to 3);
// a held lead that produces no bytes adds no queue entry.
// The queue of QUEUE_DEPTH jobs lets input and output stall independently.
module utf16_to_utf8_encoder
  import u16u8_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code_unit
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // is_replacement
);

  u16u8_job_t front_job, head_job;
  logic       front_job_valid, accept, push, pop, not_empty, full;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && front_job_valid;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .code_unit     (in_tdata),
    .end_of_string (in_tlast),
    .job           (front_job),
    .job_valid     (front_job_valid)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (front_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (not_empty),
    .full      (full)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .head_valid (not_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
